[rtl/core/bsl_pkg.sv]
// blend segment locate: shared widths, register indexes and pipeline metadata type
// no dependencies; imported by every module of the block
`default_nettype none

package bsl_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int NUM_THR     = 8;
    localparam int THR_PER_WORD = 4;
    localparam int VAL_W       = 16;
    localparam int IDX_W       = 3;
    localparam int CNT_W       = 4;
    localparam int FRAC_W      = 17;
    localparam int REM_W       = VAL_W + 1;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENTRY_COUNT = 2'd0,
        REG_THR_LOW     = 2'd1,
        REG_THR_HIGH    = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic             valid_res;
        logic [IDX_W-1:0] lower;
        logic [IDX_W-1:0] upper;
        logic             zero_frac;
    } t_meta;

endpackage

`default_nettype wire

[rtl/core/bsl_frac_div.sv]
// pipelined restoring divider: quotient (num << 16) / den, one quotient bit per stage
// depends on bsl_pkg; metadata travels alongside the quotient
`default_nettype none

module bsl_frac_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [bsl_pkg::VAL_W-1:0]   i_num,
    input  logic [bsl_pkg::VAL_W-1:0]   i_den,
    input  bsl_pkg::t_meta              i_meta,
    output logic                        o_vld,
    output logic [bsl_pkg::FRAC_W-1:0]  o_quot,
    output bsl_pkg::t_meta              o_meta
);
    import bsl_pkg::*;

    logic [REM_W-1:0]  r_p    [FRAC_W-1];
    logic [VAL_W-1:0]  r_den  [FRAC_W-1];
    logic [FRAC_W-1:0] r_q    [FRAC_W];
    t_meta             r_meta [FRAC_W];
    logic [FRAC_W-1:0] r_vld;

    for (genvar k = 0; k < FRAC_W; k++) begin : g_step
        logic [REM_W-1:0]  p_in;
        logic [VAL_W-1:0]  d_in;
        logic [FRAC_W-1:0] q_in;
        t_meta             m_in;
        logic              v_in;
        logic              ge;

        if (k == 0) begin : g_first
            assign p_in = {1'b0, i_num};
            assign d_in = i_den;
            assign q_in = '0;
            assign m_in = i_meta;
            assign v_in = i_vld;
        end else begin : g_next
            assign p_in = r_p[k-1];
            assign d_in = r_den[k-1];
            assign q_in = r_q[k-1];
            assign m_in = r_meta[k-1];
            assign v_in = r_vld[k-1];
        end

        assign ge  = (p_in >= {1'b0, d_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]    <= {q_in[FRAC_W-2:0], ge};
                r_meta[k] <= m_in;
            end
        end

        if (k < FRAC_W - 1) begin : g_carry
            logic [REM_W-1:0] rem;

            assign rem = p_in - (ge ? {1'b0, d_in} : {REM_W{1'b0}});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_p[k]   <= rem << 1;
                    r_den[k] <= d_in;
                end
            end
        end
    end

    assign o_vld  = r_vld[FRAC_W-1];
    assign o_quot = r_q[FRAC_W-1];
    assign o_meta = r_meta[FRAC_W-1];

endmodule

`default_nettype wire

[rtl/core/blend_segment_locate_unit.sv]
// blend segment locate top level: config registers, input stage, segment search, divider
// depends on bsl_pkg and bsl_frac_div
//
//  channel  | direction | handshake            | payload
//  input    | in        | i_valid / o_ready    | i_blend_value
//  output   | out       | o_valid / i_ready    | o_valid_res, o_lower_index, o_upper_index,
//           |           |                      | o_fraction
//  config   | in        | i_cfg_wr_en          | i_cfg_index, i_cfg_wdata
//
// one transaction per cycle while the output is not stalled; 19 register stages from input to o_valid:
// input register, segment search stage, 17 divider stages
// a stalled output freezes the whole pipeline; o_ready is low only then
// synchronous active-low reset clears valid bits and config registers
`default_nettype none

module blend_segment_locate_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [bsl_pkg::VAL_W-1:0]  i_blend_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_valid_res,
    output logic [bsl_pkg::IDX_W-1:0]         o_lower_index,
    output logic [bsl_pkg::IDX_W-1:0]         o_upper_index,
    output logic [bsl_pkg::FRAC_W-1:0]        o_fraction,
    input  logic                              i_cfg_wr_en,
    input  logic [bsl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bsl_pkg::CFG_W-1:0]         i_cfg_wdata
);
    import bsl_pkg::*;

    logic [CNT_W-1:0]        r_entry_count;
    logic [CFG_W-1:0]        r_thr_low;
    logic [CFG_W-1:0]        r_thr_high;

    logic                    en;
    logic                    r_in_vld;
    logic signed [VAL_W-1:0] r_in_value;

    logic signed [VAL_W-1:0] thr [NUM_THR];
    logic [CNT_W-1:0]        cnt_lim;
    t_meta                   n_meta;
    logic [VAL_W-1:0]        n_num;
    logic [VAL_W-1:0]        n_den;

    logic                    r_cmp_vld;
    logic [VAL_W-1:0]        r_num;
    logic [VAL_W-1:0]        r_den;
    t_meta                   r_meta;

    logic                    div_vld;
    logic [FRAC_W-1:0]       div_quot;
    t_meta                   div_meta;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_thr_low     <= '0;
            r_thr_high    <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_ENTRY_COUNT: r_entry_count <= i_cfg_wdata[CNT_W-1:0];
                REG_THR_LOW:     r_thr_low     <= i_cfg_wdata;
                REG_THR_HIGH:    r_thr_high    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign en      = !(o_valid && !i_ready);
    assign o_ready = en;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (en) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_value <= i_blend_value;
        end
    end

    always_comb begin
        for (int i = 0; i < THR_PER_WORD; i++) begin
            thr[i]                = r_thr_low[i*VAL_W +: VAL_W];
            thr[i + THR_PER_WORD] = r_thr_high[i*VAL_W +: VAL_W];
        end
    end

    assign cnt_lim = (r_entry_count > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : r_entry_count;

    // segment search: first enclosing pair wins
    always_comb begin
        logic                    found;
        logic [IDX_W-1:0]        sel;
        logic [IDX_W-1:0]        sel_up;
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;

        found = 1'b0;
        sel   = '0;
        for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
            if (!found && (CNT_W'(i + 1) < cnt_lim)
                    && (r_in_value >= thr[i]) && (r_in_value <= thr[i+1])) begin
                found = 1'b1;
                sel   = IDX_W'(i);
            end
        end
        sel_up   = sel + IDX_W'(1);
        a        = thr[sel];
        b        = thr[sel_up];
        n_num    = r_in_value - a;
        n_den    = b - a;

        n_meta.valid_res = (cnt_lim != '0);
        n_meta.zero_frac = !(found && (b > a));
        n_meta.lower     = '0;
        n_meta.upper     = '0;
        if (found) begin
            n_meta.lower = sel;
            n_meta.upper = sel_up;
        end else if ((cnt_lim >= CNT_W'(2)) && (r_in_value > thr[0])) begin
            n_meta.lower = IDX_W'(cnt_lim - CNT_W'(1));
            n_meta.upper = IDX_W'(cnt_lim - CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else if (en) begin
            r_cmp_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num  <= n_num;
            r_den  <= n_den;
            r_meta <= n_meta;
        end
    end

    bsl_frac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_cmp_vld),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_meta  (r_meta),
        .o_vld   (div_vld),
        .o_quot  (div_quot),
        .o_meta  (div_meta)
    );

    assign o_valid       = div_vld;
    assign o_valid_res   = div_meta.valid_res;
    assign o_lower_index = div_meta.lower;
    assign o_upper_index = div_meta.upper;
    assign o_fraction    = div_meta.zero_frac ? {FRAC_W{1'b0}} : div_quot;

endmodule

`default_nettype wire

[rtl/core/bsl_checker.sv]
// port-level checks for blend_segment_locate_unit, attached by bind
// depends on bsl_pkg widths
`default_nettype none

module bsl_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic                              i_valid_res,
    input logic [bsl_pkg::IDX_W-1:0]         i_lower_index,
    input logic [bsl_pkg::IDX_W-1:0]         i_upper_index,
    input logic [bsl_pkg::FRAC_W-1:0]        i_fraction
);
    import bsl_pkg::*;

    // pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output valid dropped before transaction");

    // input side backpressure only when output is stalled
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input ready low without output stall");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_valid_res) |->
            (i_lower_index == '0 && i_upper_index == '0 && i_fraction == '0))
        else $error("nonzero result with no entries");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_fraction[FRAC_W-1] && (i_fraction[FRAC_W-2:0] != '0)))
        else $error("fraction above one");

    a_pair_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_upper_index == i_lower_index && i_fraction == '0)
            || (i_upper_index == i_lower_index + IDX_W'(1))))
        else $error("bad index pair");

endmodule

bind blend_segment_locate_unit bsl_checker u_bsl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (o_ready),
    .i_out_valid   (o_valid),
    .i_out_ready   (i_ready),
    .i_valid_res   (o_valid_res),
    .i_lower_index (o_lower_index),
    .i_upper_index (o_upper_index),
    .i_fraction    (o_fraction)
);

`default_nettype wire
